// File: rtl/c2d_pkg.sv
`default_nettype none

package c2d_pkg;

  localparam int MAX_KERNEL = 5;
  localparam int MAX_COLS   = 256;
  localparam int MAX_ROWS   = 256;

  localparam int SMP_W  = 16;
  localparam int PROD_W = 2 * SMP_W;
  localparam int OUT_W  = 40;
  localparam int IDX_W  = 8;
  localparam int DIM_W  = 9;
  localparam int KFLD_W = 3;
  localparam int COEF_W = 5;
  localparam int CFG_W  = 16;
  localparam int REG_W  = 3;
  localparam int FRAC_W = 12;

  localparam int KDEPTH  = MAX_KERNEL * MAX_KERNEL;
  localparam int LS_ROWS = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
  localparam int GD      = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
  localparam int SLOT_W  = (LS_ROWS > 1) ? $clog2(LS_ROWS) : 1;
  localparam int WIN_W   = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
  localparam int KW      = $clog2(MAX_KERNEL + 1);
  localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int MAXW_A  = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int CMP_W   = ((MAXW_A > DIM_W) ? MAXW_A : DIM_W) + 1;

  localparam logic [REG_W-1:0] REG_IMAGE_ROWS = REG_W'(0);
  localparam logic [REG_W-1:0] REG_IMAGE_COLS = REG_W'(1);
  localparam logic [REG_W-1:0] REG_KERN_ROWS  = REG_W'(2);
  localparam logic [REG_W-1:0] REG_KERN_COLS  = REG_W'(3);
  localparam logic [REG_W-1:0] REG_BIAS_VALUE = REG_W'(4);

  localparam logic OP_COEF   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef logic signed [SMP_W-1:0]  c2d_smp_t;
  typedef logic signed [PROD_W-1:0] c2d_prod_t;
  typedef logic signed [OUT_W-1:0]  c2d_sum_t;

  typedef struct packed {
    logic             en;
    logic [WIN_W-1:0] pos;
  } c2d_lane_t;

  typedef struct packed {
    logic prod;
    logic part;
  } c2d_adv_t;

  typedef struct packed {
    logic             err;
    logic             last;
    logic [IDX_W-1:0] orow;
    logic [IDX_W-1:0] ocol;
  } c2d_meta_t;

  function automatic logic [CMP_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
    logic [CMP_W-1:0] res;
    if (v == '0) begin
      res = CMP_W'(1);
    end else if (int'(v) > hi) begin
      res = CMP_W'(hi);
    end else begin
      res = CMP_W'(v);
    end
    return res;
  endfunction

  function automatic logic [KW-1:0] clamp_kern(input logic [KFLD_W-1:0] v);
    logic [KW-1:0] res;
    if (v == '0) begin
      res = KW'(1);
    end else if (int'(v) > MAX_KERNEL) begin
      res = KW'(MAX_KERNEL);
    end else begin
      res = KW'(v);
    end
    return res;
  endfunction

  // map a row-major coefficient slot to its place in the window
  function automatic c2d_lane_t lane_map(input int lane, input logic [KW-1:0] kr,
                                         input logic [KW-1:0] kc);
    c2d_lane_t m;
    int        kri;
    int        kci;
    m   = '0;
    kri = int'(kr);
    kci = int'(kc);
    for (int ki = 0; ki < MAX_KERNEL; ki++) begin
      for (int kj = 0; kj < MAX_KERNEL; kj++) begin
        if (ki < kri && kj < kci && ki * kci + kj == lane) begin
          m.en  = 1'b1;
          m.pos = WIN_W'((MAX_KERNEL - kri + ki) * MAX_KERNEL + MAX_KERNEL - kci + kj);
        end
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// File: rtl/conv2d_valid_forward.sv
// Throughput: one item per cycle; stall ripples back through five register stages.
// Sample position, line stores (one RAM per buffered row) and the window advance at
// transfer; the multiply and the two-level adder tree follow in separate stages.
// Reset (synchronous): counters, stage valids and window clear, size/bias registers
// take their defaults; kernel and line stores are left unwritten, with no clearing pass.
`default_nettype none

module conv2d_valid_forward (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [c2d_pkg::REG_W-1:0]         cfg_index,
  input  wire logic [c2d_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_op,
  input  wire logic [c2d_pkg::COEF_W-1:0]        in_coef_index,
  input  wire logic signed [c2d_pkg::SMP_W-1:0]  in_value_in,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [c2d_pkg::OUT_W-1:0]       out_conv_out,
  output logic [c2d_pkg::IDX_W-1:0]              out_row,
  output logic [c2d_pkg::IDX_W-1:0]              out_col,
  output logic                                   out_frame_last,
  output logic                                   out_size_error
);

  import c2d_pkg::*;

  logic [DIM_W-1:0]  image_rows_r;
  logic [DIM_W-1:0]  image_cols_r;
  logic [KFLD_W-1:0] kern_rows_r;
  logic [KFLD_W-1:0] kern_cols_r;
  c2d_smp_t          bias_value_r;

  logic [CMP_W-1:0] rows_c, cols_c, kr_x, kc_x, r_x, c_x, r1, c1;
  logic [KW-1:0]    kr_c, kc_c;

  logic [ROW_W-1:0]  row_count_r, row_count_nxt;
  logic [COL_W-1:0]  col_count_r, col_count_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic      in_acc, smp_acc;
  logic      acc_err, acc_have, acc_last;
  logic [GD-1:0] acc_use;
  c2d_meta_t acc_meta;

  logic              s1_v_r, s1_op_r, s1_res_r;
  logic [COEF_W-1:0] s1_idx_r;
  c2d_smp_t          s1_val_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic [GD-1:0]     s1_use_r;
  c2d_meta_t         s1_meta_r;

  logic      s2_v_r, s3_v_r, s4_v_r;
  c2d_meta_t s2_meta_r, s3_meta_r, s4_meta_r;

  logic rdy1, rdy2, rdy3, rdy4, rdy5, adv1;

  logic [SMP_W-1:0] ram_q [LS_ROWS];
  c2d_smp_t         col_in [MAX_KERNEL];
  c2d_smp_t         win_r  [KDEPTH];
  c2d_smp_t         kern_r [KDEPTH];
  c2d_adv_t         adv;
  c2d_sum_t         sum;

  logic             out_valid_r;
  c2d_sum_t         out_conv_r;
  c2d_meta_t        out_meta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_rows_r <= DIM_W'(8);
      image_cols_r <= DIM_W'(8);
      kern_rows_r  <= KFLD_W'(3);
      kern_cols_r  <= KFLD_W'(3);
      bias_value_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_ROWS: image_rows_r <= cfg_data[DIM_W-1:0];
        REG_IMAGE_COLS: image_cols_r <= cfg_data[DIM_W-1:0];
        REG_KERN_ROWS:  kern_rows_r  <= cfg_data[KFLD_W-1:0];
        REG_KERN_COLS:  kern_cols_r  <= cfg_data[KFLD_W-1:0];
        REG_BIAS_VALUE: bias_value_r <= cfg_data[SMP_W-1:0];
        default: ;
      endcase
    end
  end

  assign rows_c = clamp_dim(image_rows_r, MAX_ROWS);
  assign cols_c = clamp_dim(image_cols_r, MAX_COLS);
  assign kr_c   = clamp_kern(kern_rows_r);
  assign kc_c   = clamp_kern(kern_cols_r);
  assign kr_x   = CMP_W'(kr_c);
  assign kc_x   = CMP_W'(kc_c);
  assign r_x    = CMP_W'(row_count_r);
  assign c_x    = CMP_W'(col_count_r);
  assign r1     = r_x + CMP_W'(1);
  assign c1     = c_x + CMP_W'(1);

  // ready chain, output side first
  assign rdy5 = !out_valid_r || !out_stall;
  assign rdy4 = !s4_v_r || rdy5;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;
  assign adv1 = s1_v_r && rdy2;

  assign in_stall = !rdy1;
  assign in_acc   = in_valid && rdy1;
  assign smp_acc  = in_acc && (in_op == OP_SAMPLE);

  always_comb begin
    acc_err  = (kr_x > rows_c) || (kc_x > cols_c);
    acc_have = (r1 >= kr_x) && (c1 >= kc_x);
    acc_last = (r1 == rows_c) && (c1 == cols_c);
    acc_meta.err  = acc_err;
    acc_meta.last = acc_last;
    acc_meta.orow = IDX_W'(r1 - kr_x);
    acc_meta.ocol = IDX_W'(c1 - kc_x);
    acc_use = '0;
    for (int d = 1; d < MAX_KERNEL; d++) begin
      acc_use[d-1] = (CMP_W'(d) <= r_x) && (CMP_W'(d) < kr_x);
    end
  end

  always_comb begin
    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    slot_nxt      = slot_r;
    if (smp_acc) begin
      if (c1 >= cols_c) begin
        col_count_nxt = '0;
        if (r1 >= rows_c) begin
          row_count_nxt = '0;
          slot_nxt      = '0;
        end else begin
          row_count_nxt = ROW_W'(r1);
          slot_nxt      = (int'(slot_r) == LS_ROWS - 1) ? '0 : slot_r + SLOT_W'(1);
        end
      end else begin
        col_count_nxt = COL_W'(c1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= '0;
      col_count_r <= '0;
      slot_r      <= '0;
    end else begin
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
      slot_r      <= slot_nxt;
    end
  end

  for (genvar s = 0; s < LS_ROWS; s++) begin : g_line
    c2d_ram #(
      .WIDTH (SMP_W),
      .DEPTH (MAX_COLS)
    ) u_line (
      .clk     (clk),
      .we      (smp_acc && (slot_r == SLOT_W'(s))),
      .wr_addr (col_count_r),
      .wr_data (in_value_in),
      .re      (smp_acc),
      .rd_addr (col_count_r),
      .rd_data (ram_q[s])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_op;
      s1_idx_r  <= in_coef_index;
      s1_val_r  <= in_value_in;
      s1_slot_r <= slot_r;
      s1_use_r  <= acc_use;
      s1_meta_r <= acc_meta;
      s1_res_r  <= (in_op == OP_SAMPLE) && (acc_err || acc_have);
    end
  end

  // new window column, oldest row first
  always_comb begin : p_col
    int d;
    int t;
    for (int ki = 0; ki < MAX_KERNEL - 1; ki++) begin
      d = MAX_KERNEL - 1 - ki;
      t = int'(s1_slot_r) + LS_ROWS - d;
      if (t >= LS_ROWS) begin
        t = t - LS_ROWS;
      end
      col_in[ki] = s1_use_r[d-1] ? ram_q[SLOT_W'(t)] : '0;
    end
    col_in[MAX_KERNEL-1] = s1_val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KDEPTH; i++) begin
        win_r[i] <= '0;
      end
    end else if (adv1 && (s1_op_r == OP_SAMPLE)) begin
      for (int ki = 0; ki < MAX_KERNEL; ki++) begin
        for (int kj = 0; kj < MAX_KERNEL - 1; kj++) begin
          win_r[ki * MAX_KERNEL + kj] <= win_r[ki * MAX_KERNEL + kj + 1];
        end
        win_r[ki * MAX_KERNEL + MAX_KERNEL - 1] <= col_in[ki];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && (s1_op_r == OP_COEF) && (int'(s1_idx_r) < KDEPTH)) begin
      kern_r[WIN_W'(s1_idx_r)] <= s1_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy2) begin
        s2_v_r <= s1_v_r && s1_res_r;
      end
      if (rdy3) begin
        s3_v_r <= s2_v_r;
      end
      if (rdy4) begin
        s4_v_r <= s3_v_r;
      end
      if (rdy5) begin
        out_valid_r <= s4_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_meta_r <= s1_meta_r;
    end
    if (adv.prod) begin
      s3_meta_r <= s2_meta_r;
    end
    if (adv.part) begin
      s4_meta_r <= s3_meta_r;
    end
    if (s4_v_r && rdy5) begin
      if (s4_meta_r.err) begin
        out_conv_r <= '0;
        out_meta_r <= '{err: 1'b1, last: 1'b0, orow: '0, ocol: '0};
      end else begin
        out_conv_r <= sum;
        out_meta_r <= s4_meta_r;
      end
    end
  end

  assign adv = '{prod: s2_v_r && rdy3, part: s3_v_r && rdy4};

  c2d_sum u_sum (
    .clk  (clk),
    .adv  (adv),
    .kr   (kr_c),
    .kc   (kc_c),
    .win  (win_r),
    .kern (kern_r),
    .bias (bias_value_r),
    .sum  (sum)
  );

  assign out_valid      = out_valid_r;
  assign out_conv_out   = out_conv_r;
  assign out_row        = out_meta_r.orow;
  assign out_col        = out_meta_r.ocol;
  assign out_frame_last = out_meta_r.last;
  assign out_size_error = out_meta_r.err;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_size_error |->
      out_conv_out == '0 && !out_frame_last && out_row == '0 && out_col == '0)
    else $error("size error result carries data");

  a_coef_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv1 && (s1_op_r == OP_COEF) |=> !s2_v_r)
    else $error("coefficient load produced a result");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !rdy2 |=> s1_v_r && $stable(s1_val_r) && $stable(s1_meta_r))
    else $error("input stage lost its item while blocked");

endmodule

`default_nettype wire

// File: rtl/c2d_ram.sv
`default_nettype none

module c2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                           wr_data,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/c2d_sum.sv
`default_nettype none

module c2d_sum (
  input  wire logic                        clk,
  input  wire c2d_pkg::c2d_adv_t           adv,
  input  wire logic [c2d_pkg::KW-1:0]      kr,
  input  wire logic [c2d_pkg::KW-1:0]      kc,
  input  wire c2d_pkg::c2d_smp_t           win  [c2d_pkg::KDEPTH],
  input  wire c2d_pkg::c2d_smp_t           kern [c2d_pkg::KDEPTH],
  input  wire c2d_pkg::c2d_smp_t           bias,
  output c2d_pkg::c2d_sum_t                sum
);

  import c2d_pkg::*;

  c2d_lane_t map_r    [KDEPTH];
  c2d_prod_t prod_nxt [KDEPTH];
  c2d_prod_t prod_r   [KDEPTH];
  c2d_sum_t  part_nxt [MAX_KERNEL];
  c2d_sum_t  part_r   [MAX_KERNEL];

  always_ff @(posedge clk) begin
    for (int i = 0; i < KDEPTH; i++) begin
      map_r[i] <= lane_map(i, kr, kc);
    end
  end

  always_comb begin
    for (int i = 0; i < KDEPTH; i++) begin
      if (map_r[i].en) begin
        prod_nxt[i] = win[map_r[i].pos] * kern[i];
      end else begin
        prod_nxt[i] = '0;
      end
    end
  end

  always_comb begin
    for (int g = 0; g < MAX_KERNEL; g++) begin
      part_nxt[g] = '0;
      for (int j = 0; j < MAX_KERNEL; j++) begin
        part_nxt[g] = part_nxt[g] + c2d_sum_t'(prod_r[g * MAX_KERNEL + j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.prod) begin
      prod_r <= prod_nxt;
    end
    if (adv.part) begin
      part_r <= part_nxt;
    end
  end

  always_comb begin
    sum = c2d_sum_t'(bias) <<< FRAC_W;
    for (int g = 0; g < MAX_KERNEL; g++) begin
      sum = sum + part_r[g];
    end
  end

endmodule

`default_nettype wire
